>>> src/rhc_pkg.sv
// types, constants and divider step functions for the rgb to hsv converter
// no dependencies; used by rhc_classify and rgb_to_hsv_converter
package rhc_pkg;

  // channel and result widths
  localparam int CH_W    = 8;
  localparam int HUE_W   = 17;
  localparam int REM_W   = 11;   // hue divisor 6*d and its remainder, up to 1530
  localparam int NUM_W   = 12;   // signed hue dividend before clamping
  localparam int DIFF_W  = 9;    // signed channel difference
  localparam int SATN_W  = 16;   // 255*d

  // offsets picked by the minimum channel, and the sector count
  localparam int I_RED_MIN   = 3;
  localparam int I_GREEN_MIN = 5;
  localparam int I_BLUE_MIN  = 1;
  localparam int HUE_SECTORS = 6;
  localparam int SAT_SCALE   = 255;

  // divider layout: one leading hue bit, then HUE_STEPS hue bits and
  // SAT_STEPS saturation bits in each of DIV_STAGES stages
  localparam int DIV_STAGES = 4;
  localparam int HUE_STEPS  = (HUE_W - 1) / DIV_STAGES;
  localparam int SAT_STEPS  = CH_W / DIV_STAGES;

  // input register, classify register, setup register, divider stages
  localparam int PIPE_DEPTH = 3 + DIV_STAGES;

  // which channel is the minimum, red tested first
  typedef enum logic [1:0] {
    SEL_RED_MIN,
    SEL_GREEN_MIN,
    SEL_BLUE_MIN
  } min_sel_t;

  // result of max/min classification
  typedef struct packed {
    logic [CH_W-1:0]          mx;
    logic [CH_W-1:0]          mn;
    min_sel_t                 sel;
    logic signed [DIFF_W-1:0] f;
  } cls_t;

  // payload of one divider stage
  typedef struct packed {
    logic [REM_W-1:0] hue_rem;
    logic [REM_W-1:0] hue_div;
    logic [HUE_W-1:0] hue_q;
    logic [CH_W-1:0]  sat_rem;
    logic [CH_W-1:0]  sat_lo;
    logic [CH_W-1:0]  sat_q;
    logic [CH_W-1:0]  mx;
    logic             undef;
  } stage_t;

  // restoring division steps for hue and saturation; lead adds the top hue bit
  function automatic stage_t div_steps(input stage_t s, input logic lead);
    stage_t           t;
    logic [REM_W:0]   hr;
    logic [CH_W:0]    sr;
    t = s;
    // top hue bit: dividend never exceeds the divisor
    if (lead) begin
      if (t.hue_rem >= t.hue_div) begin
        t.hue_rem = t.hue_rem - t.hue_div;
        t.hue_q   = HUE_W'(1);
      end else begin
        t.hue_q   = '0;
      end
    end
    // hue quotient bits, zeros shifted in
    for (int k = 0; k < HUE_STEPS; k++) begin
      hr = {t.hue_rem, 1'b0};
      if (hr >= {1'b0, t.hue_div}) begin
        hr      = hr - {1'b0, t.hue_div};
        t.hue_q = {t.hue_q[HUE_W-2:0], 1'b1};
      end else begin
        t.hue_q = {t.hue_q[HUE_W-2:0], 1'b0};
      end
      t.hue_rem = hr[REM_W-1:0];
    end
    // saturation quotient bits, low dividend bits shifted in
    for (int k = 0; k < SAT_STEPS; k++) begin
      sr       = {t.sat_rem, t.sat_lo[CH_W-1]};
      t.sat_lo = {t.sat_lo[CH_W-2:0], 1'b0};
      if (sr >= {1'b0, t.mx}) begin
        sr      = sr - {1'b0, t.mx};
        t.sat_q = {t.sat_q[CH_W-2:0], 1'b1};
      end else begin
        t.sat_q = {t.sat_q[CH_W-2:0], 1'b0};
      end
      t.sat_rem = sr[CH_W-1:0];
    end
    return t;
  endfunction

endpackage

>>> src/rhc_classify.sv
// max/min classification of one pixel and hue offset selection
// depends on rhc_pkg
module rhc_classify
  import rhc_pkg::*;
(
  input  logic [CH_W-1:0] red,
  input  logic [CH_W-1:0] green,
  input  logic [CH_W-1:0] blue,
  output cls_t            cls
);

  logic [CH_W-1:0] mx_rg;
  logic [CH_W-1:0] mn_rg;
  logic [CH_W-1:0] mn;
  logic signed [DIFF_W-1:0] d_gb;
  logic signed [DIFF_W-1:0] d_br;
  logic signed [DIFF_W-1:0] d_rg;

  // largest and smallest channel
  assign mx_rg = (red > green) ? red : green;
  assign mn_rg = (red < green) ? red : green;
  assign mn    = (mn_rg < blue) ? mn_rg : blue;

  // channel differences, formed in parallel with the compares
  assign d_gb = $signed({1'b0, green}) - $signed({1'b0, blue});
  assign d_br = $signed({1'b0, blue}) - $signed({1'b0, red});
  assign d_rg = $signed({1'b0, red}) - $signed({1'b0, green});

  // offset selection, first minimum channel wins a tie
  always_comb begin
    cls.mx = (mx_rg > blue) ? mx_rg : blue;
    cls.mn = mn;
    if (red == mn) begin
      cls.sel = SEL_RED_MIN;
      cls.f   = d_gb;
    end else if (green == mn) begin
      cls.sel = SEL_GREEN_MIN;
      cls.f   = d_br;
    end else begin
      cls.sel = SEL_BLUE_MIN;
      cls.f   = d_rg;
    end
  end

endmodule

>>> src/rgb_to_hsv_converter.sv
// rgb to hsv converter top level: pipelined max/min, setup and two dividers
// depends on rhc_pkg and rhc_classify
//
//  channel  dir  handshake          tdata                      tuser
//  in_      in   in_tvalid/tready   red, green, blue           -
//  out_     out  out_tvalid/tready  hue, saturation, brightness hue_undefined
//
// one pixel per clock while out_tready does not stall; seven register stages,
// input through last divider stage; the depth is set by the hue divider, five bits
// per stage in the first divider stage and four in each of the three after it
// stalls propagate stage by stage, so empty stages keep filling while a
// result waits; rst_n clears all valid bits, data registers hold no reset
module rgb_to_hsv_converter
  import rhc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,    // red[7:0], green[15:8], blue[23:16]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,   // hue[16:0], saturation[24:17], brightness[32:25], zero
  output logic        out_tuser    // hue_undefined[0]
);

  logic [PIPE_DEPTH-1:0] valid_r;
  logic [PIPE_DEPTH-1:0] valid_nxt;
  logic [PIPE_DEPTH-1:0] rdy;

  logic [3*CH_W-1:0] rgb_r;
  cls_t              cls_nxt;
  cls_t              cls_r;
  stage_t            stg_nxt [DIV_STAGES+1];
  stage_t            stg_r   [DIV_STAGES+1];

  logic [CH_W-1:0]         dd;
  logic [REM_W-1:0]        id;
  logic signed [NUM_W-1:0] num;

  // per-stage ready: a stage moves when empty or when the next one moves
  always_comb begin
    rdy[PIPE_DEPTH-1] = !valid_r[PIPE_DEPTH-1] || out_tready;
    for (int k = PIPE_DEPTH - 2; k >= 0; k--) begin
      rdy[k] = !valid_r[k] || rdy[k+1];
    end
  end

  assign in_tready = rdy[0];

  // valid bits travel with the data
  always_comb begin
    valid_nxt = valid_r;
    if (rdy[0]) begin
      valid_nxt[0] = in_tvalid;
    end
    for (int k = 1; k < PIPE_DEPTH; k++) begin
      if (rdy[k]) begin
        valid_nxt[k] = valid_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // classify the registered pixel
  rhc_classify u_classify (
    .red   (rgb_r[CH_W-1:0]),
    .green (rgb_r[2*CH_W-1:CH_W]),
    .blue  (rgb_r[3*CH_W-1:2*CH_W]),
    .cls   (cls_nxt)
  );

  // setup: range, hue dividend and divisor, saturation dividend
  always_comb begin
    dd = cls_r.mx - cls_r.mn;
    case (cls_r.sel)
      SEL_RED_MIN:   id = REM_W'(dd) * REM_W'(I_RED_MIN);
      SEL_GREEN_MIN: id = REM_W'(dd) * REM_W'(I_GREEN_MIN);
      SEL_BLUE_MIN:  id = REM_W'(dd) * REM_W'(I_BLUE_MIN);
      default:       id = '0;
    endcase
    num = $signed({1'b0, id}) - NUM_W'(cls_r.f);

    stg_nxt[0].hue_rem = num[NUM_W-1] ? '0 : num[REM_W-1:0];
    stg_nxt[0].hue_div = REM_W'(dd) * REM_W'(HUE_SECTORS);
    stg_nxt[0].hue_q   = '0;
    {stg_nxt[0].sat_rem, stg_nxt[0].sat_lo} = SATN_W'(dd) * SATN_W'(SAT_SCALE);
    stg_nxt[0].sat_q   = '0;
    stg_nxt[0].mx      = cls_r.mx;
    stg_nxt[0].undef   = (dd == '0);

    // divider stages; a gray pixel forces hue and saturation to zero at the end
    for (int j = 1; j <= DIV_STAGES; j++) begin
      stg_nxt[j] = div_steps(stg_r[j-1], j == 1);
    end
    if (stg_nxt[DIV_STAGES].undef) begin
      stg_nxt[DIV_STAGES].hue_q = '0;
      stg_nxt[DIV_STAGES].sat_q = '0;
    end
  end

  // data registers, loaded whenever their stage moves
  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      rgb_r <= in_tdata[3*CH_W-1:0];
    end
    if (rdy[1]) begin
      cls_r <= cls_nxt;
    end
    for (int j = 0; j <= DIV_STAGES; j++) begin
      if (rdy[2+j]) begin
        stg_r[j] <= stg_nxt[j];
      end
    end
  end

  // result word
  assign out_tvalid = valid_r[PIPE_DEPTH-1];
  assign out_tdata  = {7'b0, stg_r[DIV_STAGES].mx, stg_r[DIV_STAGES].sat_q,
                       stg_r[DIV_STAGES].hue_q};
  assign out_tuser  = stg_r[DIV_STAGES].undef;

`ifndef ASSERT_OFF
  // gray pixels carry zero hue and saturation
  a_gray_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[16:0] == 17'd0 && out_tdata[24:17] == 8'd0)
    else $error("gray pixel with nonzero hue or saturation");

  // a defined hue needs a nonzero brightness
  a_defined_bright: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[32:25] != 8'd0)
    else $error("defined hue with zero brightness");

  // hue never exceeds a full circle
  a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[16] |-> out_tdata[15:0] == 16'd0)
    else $error("hue above full circle");

  // with no result waiting the whole pipeline can move
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output");
`endif

endmodule
